### rtl/core/integer_to_ascii_formatter_macros.svh
// assertion macros shared by the formatter rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ITA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ITA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/core/ita_pkg.sv
// types, constants and control store of the integer to ascii formatter
// no dependencies
package ita_pkg;

  // width of the value field on the input item
  localparam int VALUE_W = 32;

  // digit store and field width limits
  localparam int         DIGIT_DEPTH = 10;
  localparam logic [3:0] MAX_DIGITS  = 4'd10;
  localparam logic [3:0] WIDTH_LIMIT = 4'd9;

  // divide by ten through a reciprocal: q = (v * RECIP_TEN) >> RECIP_SHIFT
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // ascii codes
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] DIGIT_TEN    = 8'd10;

  // microprogram counter
  localparam int UPC_W = 3;

  typedef struct packed {
    logic [31:0] value;
    logic        hex_mode;
    logic        upper_case;
    logic        hash_prefix;
    logic        zero_fill;
    logic [3:0]  min_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_DIG,
    OP_SETUP,
    OP_EMIT_SPACE,
    OP_EMIT_PFX0,
    OP_EMIT_PFXX,
    OP_EMIT_ZPAD,
    OP_EMIT_DIGIT
  } op_e;

  // condition that skips a step before it runs
  typedef enum logic [1:0] {
    SKIP_NEVER,
    SKIP_SPACE,
    SKIP_NO_PREFIX,
    SKIP_ZPAD
  } skip_e;

  // condition that branches to the target after a step runs
  typedef enum logic [1:0] {
    LOOP_NEVER,
    LOOP_MORE_DIGITS,
    LOOP_PAD,
    LOOP_DIGIT
  } loop_e;

  typedef struct packed {
    op_e              op;
    skip_e            skip;
    loop_e            loop;
    logic [UPC_W-1:0] target;
    logic             done;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    logic exec;
    op_e  op;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic zfill;
    logic prefix;
    logic cnt_zero;
    logic cnt_one;
    logic idx_zero;
    logic more_digits;
    logic out_free;
  } status_t;

  // operations that push a character into the output register
  function automatic logic is_emit(input op_e op);
    logic res;
    res = (op == OP_EMIT_SPACE) || (op == OP_EMIT_PFX0) || (op == OP_EMIT_PFXX) ||
          (op == OP_EMIT_ZPAD) || (op == OP_EMIT_DIGIT);
    return res;
  endfunction

  // control store
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    unique case (upc)
      3'd0: w = '{op: OP_MUL,        skip: SKIP_NEVER,     loop: LOOP_NEVER,
                  target: 3'd0, done: 1'b0};
      3'd1: w = '{op: OP_DIG,        skip: SKIP_NEVER,     loop: LOOP_MORE_DIGITS,
                  target: 3'd0, done: 1'b0};
      3'd2: w = '{op: OP_SETUP,      skip: SKIP_NEVER,     loop: LOOP_NEVER,
                  target: 3'd0, done: 1'b0};
      3'd3: w = '{op: OP_EMIT_SPACE, skip: SKIP_SPACE,     loop: LOOP_PAD,
                  target: 3'd3, done: 1'b0};
      3'd4: w = '{op: OP_EMIT_PFX0,  skip: SKIP_NO_PREFIX, loop: LOOP_NEVER,
                  target: 3'd0, done: 1'b0};
      3'd5: w = '{op: OP_EMIT_PFXX,  skip: SKIP_NO_PREFIX, loop: LOOP_NEVER,
                  target: 3'd0, done: 1'b0};
      3'd6: w = '{op: OP_EMIT_ZPAD,  skip: SKIP_ZPAD,      loop: LOOP_PAD,
                  target: 3'd6, done: 1'b0};
      3'd7: w = '{op: OP_EMIT_DIGIT, skip: SKIP_NEVER,     loop: LOOP_DIGIT,
                  target: 3'd7, done: 1'b1};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/ita_sequencer.sv
// microprogram sequencer: step counter, control store lookup, skips and branches
// depends on ita_pkg and the macros header
`include "integer_to_ascii_formatter_macros.svh"

module ita_sequencer
  import ita_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_accept_i,
  input  status_t status_i,
  output logic    busy_o,
  output ctrl_t   ctrl_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  logic             busy_q, busy_d;
  ucode_t           word;
  logic             skip_hit;
  logic             loop_hit;
  logic             stall;
  logic             exec;

  // current control word
  assign word = ucode_rom(upc_q);

  // skip test ahead of the step
  always_comb begin
    unique case (word.skip)
      SKIP_NEVER:     skip_hit = 1'b0;
      SKIP_SPACE:     skip_hit = status_i.zfill || status_i.cnt_zero;
      SKIP_NO_PREFIX: skip_hit = !status_i.prefix;
      SKIP_ZPAD:      skip_hit = !status_i.zfill || status_i.cnt_zero;
    endcase
  end

  // branch test after the step
  always_comb begin
    unique case (word.loop)
      LOOP_NEVER:       loop_hit = 1'b0;
      LOOP_MORE_DIGITS: loop_hit = status_i.more_digits;
      LOOP_PAD:         loop_hit = !status_i.cnt_one;
      LOOP_DIGIT:       loop_hit = !status_i.idx_zero;
    endcase
  end

  // a character step waits for a free output register
  assign stall = is_emit(word.op) && !status_i.out_free;
  assign exec  = busy_q && !skip_hit && !stall;

  // next step
  always_comb begin
    upc_d  = upc_q;
    busy_d = busy_q;
    if (in_accept_i) begin
      upc_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (skip_hit) begin
        upc_d = upc_q + 1'b1;
      end else if (exec) begin
        if (loop_hit) begin
          upc_d = word.target;
        end else if (word.done) begin
          upc_d  = '0;
          busy_d = 1'b0;
        end else begin
          upc_d = upc_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o      = busy_q;
  assign ctrl_o.load = in_accept_i;
  assign ctrl_o.exec = exec;
  assign ctrl_o.op   = word.op;

  `ITA_ASSERT(a_emit_needs_room, (exec && is_emit(word.op)) |-> status_i.out_free, "no room")
  `ITA_ASSERT_NEVER(a_skip_on_last_step, busy_q && word.done && skip_hit, "last step skipped")
  `ITA_ASSERT_NEVER(a_accept_while_busy, in_accept_i && busy_q, "item taken while busy")

endmodule

### rtl/core/ita_datapath.sv
// datapath: working value, digit store, pad and index counters, output register
// depends on ita_pkg and the macros header
`include "integer_to_ascii_formatter_macros.svh"

module ita_datapath
  import ita_pkg::*;
#(
  parameter int VALUE_BITS = 32
)(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_t     ctrl_i,
  input  in_item_t  in_item_i,
  input  logic      out_ready_i,
  output status_t   status_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  localparam int EFF_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int PROD_W   = EFF_BITS + 32;

  logic [EFF_BITS-1:0] work_q;
  logic [PROD_W-1:0]   prod_q;
  logic [3:0]          digit_store_q [DIGIT_DEPTH];
  logic                hex_q, upper_q, prefix_q, zfill_q;
  logic [3:0]          width_q;
  logic [3:0]          n_q;
  logic [3:0]          cnt_q;
  logic [3:0]          idx_q;
  logic                out_valid_q;
  out_item_t           out_item_q;

  logic [EFF_BITS-1:0] quot_dec, quot_hex, quot, times_ten, rem;
  logic [3:0]          new_digit;
  logic [3:0]          width_sat;
  logic [3:0]          pad;
  logic [3:0]          rd_digit;
  logic [7:0]          digit_char;
  logic                emit;
  logic                out_free;

  // divide by ten from the registered product, or by sixteen by a shift
  assign quot_dec  = EFF_BITS'(prod_q[PROD_W-1:RECIP_SHIFT]);
  assign quot_hex  = work_q >> 4;
  assign times_ten = (quot_dec << 3) + (quot_dec << 1);
  assign rem       = work_q - times_ten;
  assign quot      = hex_q ? quot_hex : quot_dec;
  assign new_digit = hex_q ? work_q[3:0] : rem[3:0];

  // field width and padding
  assign width_sat = (in_item_i.min_width > WIDTH_LIMIT) ? WIDTH_LIMIT : in_item_i.min_width;
  assign pad       = (width_q > n_q) ? (width_q - n_q) : 4'd0;

  // digit to ascii
  assign rd_digit = digit_store_q[idx_q];
  always_comb begin
    if (8'(rd_digit) >= DIGIT_TEN) begin
      digit_char = 8'(rd_digit) - DIGIT_TEN + (upper_q ? CHAR_UPPER_A : CHAR_LOWER_A);
    end else begin
      digit_char = 8'(rd_digit) + CHAR_ZERO;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = ctrl_i.exec && is_emit(ctrl_i.op);

  // item load, digit extraction, and pad and index counting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q   <= '0;
      n_q      <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      hex_q    <= 1'b0;
      upper_q  <= 1'b0;
      prefix_q <= 1'b0;
      zfill_q  <= 1'b0;
      width_q  <= '0;
    end else if (ctrl_i.load) begin
      work_q   <= in_item_i.value[EFF_BITS-1:0];
      hex_q    <= in_item_i.hex_mode;
      upper_q  <= in_item_i.hex_mode && in_item_i.upper_case;
      prefix_q <= in_item_i.hex_mode && in_item_i.hash_prefix;
      zfill_q  <= in_item_i.zero_fill;
      width_q  <= width_sat;
      n_q      <= '0;
    end else if (ctrl_i.exec) begin
      unique case (ctrl_i.op)
        OP_DIG: begin
          work_q <= quot;
          n_q    <= n_q + 4'd1;
        end
        OP_SETUP: begin
          cnt_q <= pad;
          idx_q <= n_q - 4'd1;
        end
        OP_EMIT_SPACE, OP_EMIT_ZPAD: cnt_q <= cnt_q - 4'd1;
        OP_EMIT_DIGIT:               idx_q <= idx_q - 4'd1;
        default: ;
      endcase
    end
  end

  // product and digit store carry no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && ctrl_i.op == OP_MUL) begin
      prod_q <= PROD_W'(work_q) * PROD_W'(RECIP_TEN);
    end
    if (ctrl_i.exec && ctrl_i.op == OP_DIG) begin
      digit_store_q[n_q] <= new_digit;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      unique case (ctrl_i.op)
        OP_EMIT_SPACE: out_item_q <= '{out_char: CHAR_SPACE, last_char: 1'b0};
        OP_EMIT_PFX0:  out_item_q <= '{out_char: CHAR_ZERO,  last_char: 1'b0};
        OP_EMIT_PFXX:  out_item_q <= '{out_char: upper_q ? CHAR_UPPER_X : CHAR_LOWER_X,
                                       last_char: 1'b0};
        OP_EMIT_ZPAD:  out_item_q <= '{out_char: CHAR_ZERO,  last_char: 1'b0};
        default:       out_item_q <= '{out_char: digit_char, last_char: (idx_q == 4'd0)};
      endcase
    end
  end

  // status for the sequencer
  assign status_o.zfill       = zfill_q;
  assign status_o.prefix      = prefix_q;
  assign status_o.cnt_zero    = (cnt_q == 4'd0);
  assign status_o.cnt_one     = (cnt_q == 4'd1);
  assign status_o.idx_zero    = (idx_q == 4'd0);
  assign status_o.more_digits = (quot != '0) && (n_q < MAX_DIGITS - 4'd1);
  assign status_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ITA_ASSERT(a_store_in_range, (ctrl_i.exec && ctrl_i.op == OP_DIG) |-> (n_q < MAX_DIGITS), "digit store written past its depth")
  `ITA_ASSERT(a_pad_no_underflow, (ctrl_i.exec && (ctrl_i.op == OP_EMIT_SPACE || ctrl_i.op == OP_EMIT_ZPAD)) |-> (cnt_q != 4'd0), "pad counter underflow")
  `ITA_ASSERT(a_digit_read_valid, (ctrl_i.exec && ctrl_i.op == OP_EMIT_DIGIT) |-> (idx_q < n_q), "digit read beyond the extracted digits")

endmodule

### rtl/core/integer_to_ascii_formatter.sv
// flow: a two-step divide-by-ten loop extracts the digits, hex digits also taking two steps each;
// then characters go through the output register one per cycle within each run of spaces, zeros
// or digits, while output back-pressure allows; the next item is taken once the last character
// of the previous one is in the output register
// reset: asynchronous active low, clears sequencer, counters and output valid; no clearing pass
module integer_to_ascii_formatter
  import ita_pkg::*;
#(
  parameter int VALUE_BITS = 32
)(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic    busy;
  logic    in_accept;
  ctrl_t   ctrl;
  status_t status;

  // a new item is taken once the previous one has written its last character into the output register
  assign in_ready_o = !busy;
  assign in_accept  = in_valid_i && !busy;

  ita_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .status_i    (status),
    .busy_o      (busy),
    .ctrl_o      (ctrl)
  );

  ita_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

### sim/integer_to_ascii_formatter_tb.sv
// self-checking testbench for integer_to_ascii_formatter: numbers in, ascii characters out
// depends on ita_pkg for the item structs and ascii codes, and on the formatter rtl
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
  import ita_pkg::*;

  // one number waiting to be sent, with the idle rates in force while it is sent
  typedef struct {
    in_item_t    item;
    int unsigned send_idle;
    int unsigned recv_idle;
    bit          settle;
  } number_entry_t;

  logic      clk_i       = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_item     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_item;

  number_entry_t numbers_to_send[$];
  out_item_t     expected_chars[$];
  int unsigned   chars_pending   = 0;
  int unsigned   recv_idle_pct   = 0;
  int unsigned   phase_send_idle = 13;
  int unsigned   phase_recv_idle = 58;
  int unsigned   mismatch_count  = 0;

  integer_to_ascii_formatter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // expected text of one number, one character per entry, last one flagged
  function automatic void predict_text(input in_item_t it);
    logic [3:0]  digits [10];
    logic [31:0] rest;
    logic [31:0] base;
    logic [7:0]  text [$];
    logic [7:0]  ch;
    logic        upper;
    logic        prefix;
    int unsigned width;
    int unsigned n;
    int unsigned pad;
    out_item_t   o;
    upper  = it.hex_mode & it.upper_case;
    prefix = it.hex_mode & it.hash_prefix;
    base   = it.hex_mode ? 32'd16 : 32'd10;
    width  = (it.min_width > 4'd9) ? 9 : it.min_width;
    // digits, least significant first
    rest = it.value;
    n    = 0;
    do begin
      digits[n] = 4'(rest % base);
      rest      = rest / base;
      n++;
    end while (rest != 0 && n < 10);
    pad = (width > n) ? width - n : 0;
    // spaces go before the prefix, zeros after it
    if (!it.zero_fill) begin
      repeat (pad) text.push_back(CHAR_SPACE);
    end
    if (prefix) begin
      text.push_back(CHAR_ZERO);
      text.push_back(upper ? CHAR_UPPER_X : CHAR_LOWER_X);
    end
    if (it.zero_fill) begin
      repeat (pad) text.push_back(CHAR_ZERO);
    end
    for (int i = n - 1; i >= 0; i--) begin
      if (digits[i] >= 4'd10) begin
        ch = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(digits[i]) - 8'd10;
      end else begin
        ch = CHAR_ZERO + 8'(digits[i]);
      end
      text.push_back(ch);
    end
    foreach (text[i]) begin
      o.out_char  = text[i];
      o.last_char = (i == text.size() - 1);
      expected_chars.push_back(o);
    end
  endfunction

  function automatic in_item_t make_item(input logic [31:0] v, input logic h, input logic u,
                                         input logic p, input logic z, input logic [3:0] w);
    in_item_t it;
    it.value       = v;
    it.hex_mode    = h;
    it.upper_case  = u;
    it.hash_prefix = p;
    it.zero_fill   = z;
    it.min_width   = w;
    return it;
  endfunction

  // values that stress digit counts and boundaries
  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 99);
      2: return $urandom_range(0, 15);
      3: return 32'd1 << $urandom_range(0, 31);
      4: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        return p - $urandom_range(0, 1);
      end
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic add_number(input in_item_t it, input bit settle);
    number_entry_t e;
    e.item      = it;
    e.send_idle = phase_send_idle;
    e.recv_idle = phase_recv_idle;
    e.settle    = settle;
    numbers_to_send.push_back(e);
  endtask

  task automatic report_failure(input string msg);
    if (mismatch_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // driver: next number from the queue, random gaps, optional settle until drained
  always @(posedge clk_i or negedge rst_n) begin
    number_entry_t e;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else if (!in_valid || in_ready) begin
      if (numbers_to_send.size() != 0 &&
          !(numbers_to_send[0].settle && (in_valid || chars_pending != 0)) &&
          $urandom_range(0, 99) >= numbers_to_send[0].send_idle) begin
        e = numbers_to_send.pop_front();
        in_item       <= e.item;
        in_valid      <= 1'b1;
        recv_idle_pct <= e.recv_idle;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on input handshake, compare on output handshake, random back-pressure
  always @(posedge clk_i or negedge rst_n) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready     <= 1'b0;
      chars_pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(in_item);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_failure($sformatf("unexpected character %h last %b",
                                   out_item.out_char, out_item.last_char));
        end else begin
          want = expected_chars.pop_front();
          if (out_item.out_char !== want.out_char) begin
            report_failure($sformatf("out_char expected %h got %h",
                                     want.out_char, out_item.out_char));
          end
          if (out_item.last_char !== want.last_char) begin
            report_failure($sformatf("last_char expected %b got %b (char %h)",
                                     want.last_char, out_item.last_char, want.out_char));
          end
        end
      end
      chars_pending <= expected_chars.size();
      out_ready     <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // stimulus and end of run
  initial begin
    // directed: zero, extremes, padding, prefix and width corner cases
    add_number(make_item(32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 4'd0),  1'b0);
    add_number(make_item(32'd0,          1'b1, 1'b0, 1'b1, 1'b1, 4'd9),  1'b0);
    add_number(make_item(32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0, 4'd0),  1'b0);
    add_number(make_item(32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, 1'b0, 4'd0),  1'b0);
    add_number(make_item(32'hFFFF_FFFF,  1'b1, 1'b0, 1'b1, 1'b1, 4'd15), 1'b0);
    add_number(make_item(32'd5,          1'b0, 1'b0, 1'b0, 1'b0, 4'd9),  1'b0);
    add_number(make_item(32'd5,          1'b0, 1'b0, 1'b0, 1'b1, 4'd9),  1'b0);
    add_number(make_item(32'hAB,         1'b1, 1'b0, 1'b1, 1'b0, 4'd9),  1'b0);
    add_number(make_item(32'd1234567890, 1'b0, 1'b1, 1'b1, 1'b0, 4'd4),  1'b0);
    add_number(make_item(32'd7,          1'b0, 1'b0, 1'b0, 1'b1, 4'd12), 1'b0);
    add_number(make_item(32'd123456,     1'b0, 1'b0, 1'b0, 1'b1, 4'd3),  1'b0);
    add_number(make_item(32'hDEAD_BEEF,  1'b1, 1'b0, 1'b0, 1'b0, 4'd8),  1'b0);
    add_number(make_item(32'h0A0B_0C0D,  1'b1, 1'b1, 1'b0, 1'b1, 4'd14), 1'b0);
    add_number(make_item(32'd1000000000, 1'b0, 1'b0, 1'b0, 1'b0, 4'd10), 1'b0);
    add_number(make_item(32'd9,          1'b0, 1'b0, 1'b0, 1'b0, 4'd1),  1'b0);
    add_number(make_item(32'd0,          1'b1, 1'b1, 1'b1, 1'b0, 4'd0),  1'b0);
    add_number(make_item(32'h8000_0000,  1'b1, 1'b0, 1'b1, 1'b1, 4'd8),  1'b0);
    add_number(make_item(32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b1, 4'd15), 1'b0);
    add_number(make_item(32'd10,         1'b1, 1'b1, 1'b0, 1'b0, 4'd2),  1'b0);
    add_number(make_item(32'd1,          1'b1, 1'b0, 1'b1, 1'b0, 4'd15), 1'b0);
    add_number(make_item(32'd0,          1'b0, 1'b0, 1'b1, 1'b1, 4'd11), 1'b0);

    // random: three phases of idling, each later phase starts from a drained block
    for (int phase = 0; phase < 3; phase++) begin
      phase_send_idle = (phase == 0) ? 13 : (phase == 1) ? 58 : 0;
      phase_recv_idle = (phase == 0) ? 58 : (phase == 1) ? 13 : 0;
      for (int k = 0; k < 120; k++) begin
        add_number(make_item(pick_value(), 1'($urandom()), 1'($urandom()), 1'($urandom()),
                             1'($urandom()), 4'($urandom_range(0, 15))),
                   (phase != 0) && (k == 0));
      end
    end

    // hold reset, then release it
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    // wait for every number to go in and every character to come out
    @(negedge clk_i);
    while (numbers_to_send.size() != 0 || in_valid || chars_pending != 0) begin
      @(negedge clk_i);
    end
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
